// File: design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the record sorter
// Record layout, chain depth and the state encoding used by the sorter.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int DEPTH   = 16;
  localparam int KEY_W   = 8;
  localparam int IDENT_W = 24;
  localparam int TAG_W   = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [IDENT_W-1:0] ident;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  // Chain operation broadcast to every cell.
  typedef struct packed {
    logic ins;  // insert the incoming record, shifting lower entries right
    logic shl;  // shift every entry one place toward the head
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_LOAD = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

// File: design/rsd_cell.sv
// ----------------------------------------------------------------------------
// rsd_cell: one compare-insert cell of the sorting chain
// Holds one record and decides, against the broadcast record, whether it
// keeps it, takes the new one or the left entry, or shifts in the right one.
// ----------------------------------------------------------------------------
module rsd_cell (
  input  logic              clk,
  input  rsd_pkg::cell_ctl_t ctl,
  input  logic              empty,
  input  rsd_pkg::rec_t     new_rec,
  input  logic              left_take,
  input  rsd_pkg::rec_t     left_rec,
  input  rsd_pkg::rec_t     right_rec,
  output rsd_pkg::rec_t     rec,
  output logic              take
);
  import rsd_pkg::*;

  // Strictly lower only, so equal scores stay in arrival order.
  assign take = empty || (rec.key < new_rec.key);

  always_ff @(posedge clk) begin
    if (ctl.shl) begin
      rec <= right_rec;
    end else if (ctl.ins) begin
      if (left_take) begin
        rec <= left_rec;
      end else if (take) begin
        rec <= new_rec;
      end
    end
  end

endmodule

// File: design/record_sort_descending_unit.sv
// ----------------------------------------------------------------------------
// record_sort_descending_unit: stable descending record sorter
// Loads records into a chain of compare-insert cells, kept sorted by score
// with every insert, and shifts the sorted set out after the closing record.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | start && !busy      | score, ident, record_no, last
//  result   | valid (one cycle)   | out_score, out_ident, out_record_no,
//           |                     | out_last, overflow
//
// One record is taken per cycle while loading. A beat with last set starts
// the unload: busy stays high until each stored record (1 to DEPTH) is out,
// and the results follow back to back, the first once the state and then
// the head are registered. The record loop is the cell chain: one insert
// or one shift per cycle. Reset (rst, synchronous) empties the set; the
// cell contents are not cleared. The receiver cannot stall the result beats.
module record_sort_descending_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rsd_pkg::KEY_W-1:0]   score,
  input  logic [rsd_pkg::IDENT_W-1:0] ident,
  input  logic [rsd_pkg::TAG_W-1:0]   record_no,
  input  logic                        last,
  output logic                        valid,
  output logic [rsd_pkg::KEY_W-1:0]   out_score,
  output logic [rsd_pkg::IDENT_W-1:0] out_ident,
  output logic [rsd_pkg::TAG_W-1:0]   out_record_no,
  output logic                        out_last,
  output logic                        overflow
);
  import rsd_pkg::*;

  state_t          state;
  logic [CNT_W-1:0] fill_count;
  logic            overflow_seen;
  logic            accept;
  cell_ctl_t       ctl;
  rec_t            new_rec;
  rec_t            cell_rec [DEPTH];
  logic            cell_take [DEPTH];

  assign busy    = (state == S_EMIT);
  assign accept  = start && !busy;
  assign new_rec = '{key: score, ident: ident, tag: record_no};

  always_comb begin
    ctl.ins = accept && (fill_count < CNT_W'(DEPTH));
    ctl.shl = busy;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rsd_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .empty     (CNT_W'(i) >= fill_count),
      .new_rec   (new_rec),
      .left_take ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i - 1]),
      .left_rec  (cell_rec[(i == 0) ? 0 : i - 1]),
      .right_rec (cell_rec[(i == DEPTH - 1) ? i : i + 1]),
      .rec       (cell_rec[i]),
      .take      (cell_take[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      valid         <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (ctl.ins) begin
              fill_count <= fill_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          valid      <= 1'b1;
          fill_count <= fill_count - 1'b1;
          if (fill_count == CNT_W'(1)) begin
            state         <= S_LOAD;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Result payload is taken from the head of the chain as it shifts.
  always_ff @(posedge clk) begin
    if (busy) begin
      out_score     <= cell_rec[0].key;
      out_ident     <= cell_rec[0].ident;
      out_record_no <= cell_rec[0].tag;
      out_last      <= (fill_count == CNT_W'(1));
      overflow      <= overflow_seen;
    end
  end

endmodule

// File: design/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker: port-level checks of the record sorter
// Watches the command and result ports for ordering of busy and result beats.
// ----------------------------------------------------------------------------
module rsd_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic valid,
  input logic out_last
);

  // A closing beat always starts an unload.
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("closing beat did not start the unload");

  // A result beat that is not final leaves more to come.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_last) |-> busy)
    else $error("unload ended before the final result");

  // The final result beat coincides with the block being free again.
  a_final_free: assert property (@(posedge clk) disable iff (rst)
    (valid && out_last) |-> !busy)
    else $error("block still busy on the final result");

  // A result beat is seen only when busy was high in the previous cycle.
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result beat outside an unload");

endmodule

bind record_sort_descending_unit rsd_checker u_rsd_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .last     (last),
  .valid    (valid),
  .out_last (out_last)
);

// File: tb/sv/tb_record_sort_descending_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_sort_descending_unit: self-checking bench for the record sorter
// Loads sets of records through the start/busy port, predicts the stable
// descending order of every closed set, and checks each emitted beat.
// ----------------------------------------------------------------------------
module tb_record_sort_descending_unit;
  import rsd_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = DEPTH + 8;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    rec_t rec;
    logic is_last;
    logic dropped;
  } sorted_beat_t;

  typedef struct {
    rec_t         rec;
    logic         closes;
    bit           typed;
    sorted_beat_t typed_beat;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic [KEY_W-1:0]    score     = '0;
  logic [IDENT_W-1:0]  ident     = '0;
  logic [TAG_W-1:0]    record_no = '0;
  logic                last      = 1'b0;
  logic                busy;
  logic                valid;
  logic [KEY_W-1:0]    out_score;
  logic [IDENT_W-1:0]  out_ident;
  logic [TAG_W-1:0]    out_record_no;
  logic                out_last;
  logic                overflow;

  // Predictor state: the records of the open set and the drop flag.
  rec_t         held_recs [DEPTH];
  int unsigned  held_count = 0;
  logic         drop_seen  = 1'b0;
  sorted_beat_t sorted_due [$];
  stim_row_t    stim_rows [$];

  int unsigned mismatches     = 0;
  int unsigned beats_checked  = 0;
  int unsigned records_sent   = 0;
  int unsigned sets_closed    = 0;
  int unsigned overflow_sets  = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count    = 0;

  record_sort_descending_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .score        (score),
    .ident        (ident),
    .record_no    (record_no),
    .last         (last),
    .valid        (valid),
    .out_score    (out_score),
    .out_ident    (out_ident),
    .out_record_no(out_record_no),
    .out_last     (out_last),
    .overflow     (overflow)
  );

  always #10 clk = ~clk;

  function automatic void add_row(logic [KEY_W-1:0] k, logic [IDENT_W-1:0] id,
                                  logic [TAG_W-1:0] tg, logic cl, bit typed,
                                  sorted_beat_t want);
    stim_row_t row;
    row.rec        = '{key: k, ident: id, tag: tg};
    row.closes     = cl;
    row.typed      = typed;
    row.typed_beat = want;
    stim_rows.push_back(row);
  endfunction

  // Stores one record of the set; a closing record sorts the set and queues
  // its beats. With queue_beats clear the caller supplies the expectation.
  function automatic void absorb_record(rec_t r, logic closes, bit queue_beats);
    rec_t moving;
    int   slot;
    if (held_count < DEPTH) begin
      held_recs[held_count] = r;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (closes) begin
      // A record only moves ahead of strictly lower scores, so ties stay in order.
      for (int pos = 1; pos < held_count; pos++) begin
        moving = held_recs[pos];
        slot   = pos;
        while (slot > 0 && held_recs[slot-1].key < moving.key) begin
          held_recs[slot] = held_recs[slot-1];
          slot--;
        end
        held_recs[slot] = moving;
      end
      if (queue_beats) begin
        for (int i = 0; i < held_count; i++) begin
          sorted_due.push_back('{rec: held_recs[i], is_last: (i == held_count - 1),
                                 dropped: drop_seen});
        end
      end
      sets_closed++;
      if (drop_seen) overflow_sets++;
      held_count = 0;
      drop_seen  = 1'b0;
    end
  endfunction

  function automatic void log_mismatch(string why, bit have_want, sorted_beat_t want);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      if (have_want) begin
        $display("[%0t] %s: expected score=%0d ident=%06h rec=%0d last=%0b ovf=%0b",
                 $realtime, why, want.rec.key, want.rec.ident, want.rec.tag,
                 want.is_last, want.dropped);
      end else begin
        $display("[%0t] %s: no beat was due", $realtime, why);
      end
      $display("            actual   score=%0d ident=%06h rec=%0d last=%0b ovf=%0b",
               out_score, out_ident, out_record_no, out_last, overflow);
    end
  endfunction

  // Presents one record and holds it until the sorter takes it.
  task automatic drive_record(rec_t r, logic closes);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    score     <= r.key;
    ident     <= r.ident;
    record_no <= r.tag;
    last      <= closes;
    do begin
      @(posedge clk);
      taken = !busy;
      if (!taken) @(negedge clk);
    end while (!taken);
    records_sent++;
  endtask

  // Lowers start and waits until every queued beat has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    sorted_beat_t want;
    if (!rst && valid) begin
      beats_checked++;
      if (sorted_due.size() == 0) begin
        log_mismatch("unexpected beat", 1'b0, want);
      end else begin
        want = sorted_due.pop_front();
        if (out_score !== want.rec.key || out_ident !== want.rec.ident ||
            out_record_no !== want.rec.tag || out_last !== want.is_last ||
            overflow !== want.dropped) begin
          log_mismatch("beat mismatch", 1'b1, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.",
               cycle_count, sorted_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sorted_beat_t none;
    rec_t         r;
    int unsigned  rand_items;
    int unsigned  set_size;
    int unsigned  pick;
    int unsigned  phase;
    int unsigned  prev_phase;
    int unsigned  score_mode;

    none = '{rec: '0, is_last: 1'b0, dropped: 1'b0};

    // Single-record sets after reset: the record comes straight back.
    add_row(8'd0, 24'h000000, 8'd0, 1'b1, 1'b1,
            '{rec: '{key: 8'd0, ident: 24'h000000, tag: 8'd0}, is_last: 1'b1,
              dropped: 1'b0});
    add_row(8'd255, 24'hFFFFFF, 8'd255, 1'b1, 1'b1,
            '{rec: '{key: 8'd255, ident: 24'hFFFFFF, tag: 8'd255}, is_last: 1'b1,
              dropped: 1'b0});
    // All scores equal: arrival order must survive.
    add_row(8'd7, 24'h000001, 8'd1, 1'b0, 1'b0, none);
    add_row(8'd7, 24'h000002, 8'd2, 1'b0, 1'b0, none);
    add_row(8'd7, 24'h000003, 8'd3, 1'b1, 1'b0, none);
    // A tie split by a higher score.
    add_row(8'd200, 24'h0B0B0B, 8'd11, 1'b0, 1'b0, none);
    add_row(8'd255, 24'h0C0C0C, 8'd12, 1'b0, 1'b0, none);
    add_row(8'd200, 24'h0D0D0D, 8'd13, 1'b1, 1'b0, none);
    // A full store, then a closing record that is dropped.
    for (int i = 0; i < DEPTH; i++) begin
      add_row(KEY_W'(i * 17), IDENT_W'(i * 24'h111111), TAG_W'(100 + i), 1'b0, 1'b0,
              none);
    end
    add_row(8'd128, 24'h555555, 8'd99, 1'b1, 1'b0, none);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      drive_record(stim_rows[i].rec, stim_rows[i].closes);
      if (stim_rows[i].typed) begin
        sorted_due.push_back(stim_rows[i].typed_beat);
        absorb_record(stim_rows[i].rec, stim_rows[i].closes, 1'b0);
      end else begin
        absorb_record(stim_rows[i].rec, stim_rows[i].closes, 1'b1);
      end
    end
    drain_results();

    rand_items = 0;
    prev_phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      phase = (rand_items * 4) / RANDOM_ITEMS;
      if (phase != prev_phase) begin
        drain_results();
        prev_phase = phase;
      end
      case (phase)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 86;
        2: sender_idle_pct = 24;
        default: sender_idle_pct = ($urandom_range(0, 1) != 0) ? 86 : 0;
      endcase

      // Mostly short sets; some longer or full ones and a few that overflow.
      pick = $urandom_range(0, 99);
      if (pick < 70)      set_size = $urandom_range(1, 5);
      else if (pick < 88) set_size = $urandom_range(6, DEPTH - 1);
      else if (pick < 95) set_size = DEPTH;
      else                set_size = $urandom_range(DEPTH + 1, DEPTH + 4);
      score_mode = $urandom_range(0, 3);

      for (int i = 0; i < set_size; i++) begin
        case (score_mode)
          0:       r.key = KEY_W'($urandom_range(0, 3));
          1:       r.key = KEY_W'($urandom_range(252, 255));
          default: r.key = KEY_W'($urandom);
        endcase
        r.ident = IDENT_W'($urandom);
        r.tag   = TAG_W'($urandom_range(0, 255));
        drive_record(r, (i == set_size - 1));
        absorb_record(r, (i == set_size - 1), 1'b1);
        rand_items++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sorted_due.size() != 0) begin
      $display("%0d expected beats never arrived.", sorted_due.size());
    end
    $display("Sent %0d records in %0d sets, %0d of them overflowing the store.",
             records_sent, sets_closed, overflow_sets);
    $display("Checked %0d sorted beats, %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
